[hdl/ppu_pkg.sv]
package ppu_pkg;

   localparam int MAX_PARTICLES = 64;
   localparam int IDX_W = $clog2(MAX_PARTICLES);
   localparam int CNT_W = $clog2(MAX_PARTICLES + 1);

   localparam logic [19:0] GRAVITY_RESET = 20'd64225;
   localparam logic [16:0] ALPHA_ONE = 17'd65536;
   localparam logic [30:0] TINY_LIFE = 31'd6;
   localparam int DIV_STEPS = 17;

   localparam int REQ_TDATA_W = 312;
   localparam int RSP_TDATA_W = 176;

   // Request kinds
   localparam logic OP_EMIT = 1'b0;
   localparam logic OP_TICK = 1'b1;

   // Result kinds
   localparam logic [1:0] KIND_EMIT = 2'd0;
   localparam logic [1:0] KIND_PARTICLE = 2'd1;
   localparam logic [1:0] KIND_EMPTY = 2'd2;

   // One stored particle
   typedef struct packed {
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
      logic signed [31:0] vel_x;
      logic signed [31:0] vel_y;
      logic signed [31:0] vel_z;
      logic [30:0] life;
      logic [30:0] init_life;
      logic [16:0] init_alpha;
      logic [16:0] alpha;
      logic [30:0] size;
      logic [23:0] color;
   } particle_type;

   typedef enum logic [12:0] {
      ST_IDLE  = 13'b0000000000001,
      ST_SEND  = 13'b0000000000010,
      ST_GRAV  = 13'b0000000000100,
      ST_GRAVW = 13'b0000000001000,
      ST_READ  = 13'b0000000010000,
      ST_LOAD  = 13'b0000000100000,
      ST_MUL   = 13'b0000001000000,
      ST_ACC   = 13'b0000010000000,
      ST_DIV   = 13'b0000100000000,
      ST_WRITE = 13'b0001000000000,
      ST_OREAD = 13'b0010000000000,
      ST_OLOAD = 13'b0100000000000,
      ST_OSEND = 13'b1000000000000
   } state_type;

endpackage

[hdl/particle_pool_update.sv]
// Particle pool of up to 64 particles held in one on-chip memory (one write, one registered
// read port). A tick word walks the pool through a single 33x17 multiplier and a 17-step
// restoring divider: a dead particle is dropped, a survivor is stepped and written back, and its
// fade goes through the divider only when it needs the divide; the survivors are then streamed
// out one per response word. The block takes no request word until the last response word of
// the previous one has been taken.
module particle_pool_update (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, start_alpha, life_span, sprite_size,
   // color_rgb, delta_time, one zero pad bit
   input  logic [ppu_pkg::REQ_TDATA_W-1:0] req_tdata,
   input  logic         req_tuser,             // opcode
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // accepted, out_pos_x, out_pos_y, out_pos_z, out_alpha, out_size, out_color, live_count
   output logic [ppu_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   output logic [1:0]   rsp_tuser,             // result_kind
   output logic         rsp_tlast,
   input  logic         csr_wr_en,
   input  logic [19:0]  csr_wr_data
);

   ppu_pkg::state_type state_ff, state_in;

   ppu_pkg::particle_type mem_ff [ppu_pkg::MAX_PARTICLES];
   ppu_pkg::particle_type rd_data_ff;
   ppu_pkg::particle_type ent_ff, ent_in;

   logic [19:0] gravity_ff;
   logic [ppu_pkg::CNT_W-1:0] count_ff, count_in;
   logic [ppu_pkg::CNT_W-1:0] idx_ff, idx_in;
   logic [ppu_pkg::CNT_W-1:0] keep_ff, keep_in;
   logic [15:0] dt_ff, dt_in;
   logic [19:0] gdt_ff, gdt_in;
   logic [1:0]  step_ff, step_in;
   logic signed [50:0] prod_ff, prod_in;
   logic [30:0] rem_ff, rem_in;
   logic [16:0] quo_ff, quo_in;
   logic [47:0] num_ff, num_in;
   logic [4:0]  div_cnt_ff, div_cnt_in;

   logic rsp_valid_ff, rsp_valid_in;
   logic [ppu_pkg::RSP_TDATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic [1:0] rsp_kind_ff, rsp_kind_in;
   logic rsp_last_ff, rsp_last_in;

   logic mem_we;
   logic [ppu_pkg::IDX_W-1:0] mem_waddr;
   ppu_pkg::particle_type mem_wdata;

   // Shared multiplier operands
   logic signed [32:0] mul_a;
   logic [16:0] mul_b;

   logic signed [31:0] life_new;
   logic signed [33:0] acc_sum;
   logic signed [32:0] vel_sum;
   logic signed [31:0] sat_sum;
   logic signed [18:0] short_alpha;
   logic [31:0] div_trial;
   logic accept;

   assign accept = req_tvalid && req_tready;
   assign req_tready = (state_ff == ppu_pkg::ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = rsp_data_ff;
   assign rsp_tuser = rsp_kind_ff;
   assign rsp_tlast = rsp_last_ff;

   function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
      if (v > 34'sh0_7FFF_FFFF) return 32'sh7FFF_FFFF;
      if (v < -34'sh0_8000_0000) return 32'sh8000_0000;
      return v[31:0];
   endfunction

   function automatic logic [16:0] clamp_alpha(input logic signed [18:0] v);
      if (v < 19'sd0) return 17'd0;
      if (v > $signed({2'b00, ppu_pkg::ALPHA_ONE})) return ppu_pkg::ALPHA_ONE;
      return v[16:0];
   endfunction

   function automatic logic [ppu_pkg::RSP_TDATA_W-1:0] pack_rsp(
      input logic acc, input ppu_pkg::particle_type p, input logic [6:0] live);
      return {live, p.color, p.size, p.alpha, p.pos_z, p.pos_y, p.pos_x, acc};
   endfunction

   // Multiplier operand select
   always_comb begin
      mul_a = '0;
      mul_b = {1'b0, dt_ff};
      if (state_ff == ppu_pkg::ST_GRAV) begin
         mul_a = {13'd0, gravity_ff};
      end else begin
         case (step_ff)
            2'd0: mul_a = {ent_ff.vel_x[31], ent_ff.vel_x};
            2'd1: mul_a = {ent_ff.vel_y[31], ent_ff.vel_y};
            2'd2: mul_a = {ent_ff.vel_z[31], ent_ff.vel_z};
            default: begin
               mul_a = {2'b00, ent_ff.life};
               mul_b = ent_ff.init_alpha;
            end
         endcase
      end
   end

   // Datapath helpers
   always_comb begin
      life_new = $signed({1'b0, rd_data_ff.life}) - $signed({16'd0, dt_ff});
      case (step_ff)
         2'd0: acc_sum = {{2{ent_ff.pos_x[31]}}, ent_ff.pos_x} + prod_ff[49:16];
         2'd1: acc_sum = {{2{ent_ff.pos_y[31]}}, ent_ff.pos_y} + prod_ff[49:16];
         default: acc_sum = {{2{ent_ff.pos_z[31]}}, ent_ff.pos_z} + prod_ff[49:16];
      endcase
      sat_sum = sat32(acc_sum);
      vel_sum = {ent_ff.vel_y[31], ent_ff.vel_y} - $signed({13'd0, gdt_ff});
      short_alpha = $signed({2'b00, ent_ff.alpha}) - $signed({3'b000, dt_ff});
      div_trial = {rem_ff, num_ff[47]};
   end

   // Sequencer
   always_comb begin
      state_in = state_ff;
      ent_in = ent_ff;
      count_in = count_ff;
      idx_in = idx_ff;
      keep_in = keep_ff;
      dt_in = dt_ff;
      gdt_in = gdt_ff;
      step_in = step_ff;
      prod_in = prod_ff;
      rem_in = rem_ff;
      quo_in = quo_ff;
      num_in = num_ff;
      div_cnt_in = div_cnt_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in = rsp_data_ff;
      rsp_kind_in = rsp_kind_ff;
      rsp_last_in = rsp_last_ff;
      mem_we = 1'b0;
      mem_waddr = keep_ff[ppu_pkg::IDX_W-1:0];
      mem_wdata = ent_ff;

      case (state_ff)
         ppu_pkg::ST_IDLE: begin
            if (accept) begin
               if (req_tuser == ppu_pkg::OP_EMIT) begin
                  ent_in.pos_x = req_tdata[31:0];
                  ent_in.pos_y = req_tdata[63:32];
                  ent_in.pos_z = req_tdata[95:64];
                  ent_in.vel_x = req_tdata[127:96];
                  ent_in.vel_y = req_tdata[159:128];
                  ent_in.vel_z = req_tdata[191:160];
                  ent_in.init_alpha = req_tdata[208:192];
                  ent_in.alpha = req_tdata[208:192];
                  ent_in.life = req_tdata[239:209];
                  ent_in.init_life = req_tdata[239:209];
                  ent_in.size = req_tdata[270:240];
                  ent_in.color = req_tdata[294:271];
                  mem_wdata = ent_in;
                  mem_waddr = count_ff[ppu_pkg::IDX_W-1:0];
                  rsp_data_in = '0;
                  if (count_ff < ppu_pkg::CNT_W'(ppu_pkg::MAX_PARTICLES)) begin
                     mem_we = 1'b1;
                     count_in = count_ff + 1'b1;
                     rsp_data_in[0] = 1'b1;
                  end
                  rsp_data_in[175:169] = 7'(count_in);
                  rsp_kind_in = ppu_pkg::KIND_EMIT;
                  rsp_last_in = 1'b1;
                  rsp_valid_in = 1'b1;
                  state_in = ppu_pkg::ST_SEND;
               end else begin
                  dt_in = req_tdata[310:295];
                  state_in = ppu_pkg::ST_GRAV;
               end
            end
         end

         ppu_pkg::ST_SEND: begin
            if (rsp_tready) begin
               rsp_valid_in = 1'b0;
               state_in = ppu_pkg::ST_IDLE;
            end
         end

         ppu_pkg::ST_GRAV: begin
            prod_in = 51'(mul_a) * 51'($signed({1'b0, mul_b}));
            state_in = ppu_pkg::ST_GRAVW;
         end

         ppu_pkg::ST_GRAVW: begin
            gdt_in = prod_ff[35:16];
            idx_in = '0;
            keep_in = '0;
            state_in = (count_ff == '0) ? ppu_pkg::ST_WRITE : ppu_pkg::ST_READ;
         end

         ppu_pkg::ST_READ: begin
            state_in = ppu_pkg::ST_LOAD;
         end

         // Life check on the fresh entry
         ppu_pkg::ST_LOAD: begin
            ent_in = rd_data_ff;
            if (life_new[31] || life_new == 32'sd0) begin
               idx_in = idx_ff + 1'b1;
               state_in = (idx_in == count_ff) ? ppu_pkg::ST_WRITE : ppu_pkg::ST_READ;
               // no write: reuse the finish path below via a flag-free check
            end else begin
               ent_in.life = life_new[30:0];
               step_in = 2'd0;
               state_in = ppu_pkg::ST_MUL;
            end
         end

         ppu_pkg::ST_MUL: begin
            prod_in = 51'(mul_a) * 51'($signed({1'b0, mul_b}));
            state_in = (step_ff == 2'd3) ? ppu_pkg::ST_DIV : ppu_pkg::ST_ACC;
            num_in = prod_in[47:0];
            rem_in = prod_in[47:17];
            div_cnt_in = '0;
            quo_in = '0;
            if (step_ff == 2'd3) num_in = {prod_in[16:0], 31'd0};
         end

         ppu_pkg::ST_ACC: begin
            step_in = step_ff + 1'b1;
            state_in = ppu_pkg::ST_MUL;
            case (step_ff)
               2'd0: ent_in.pos_x = sat_sum;
               2'd1: ent_in.pos_y = sat_sum;
               default: begin
                  ent_in.pos_z = sat_sum;
                  ent_in.vel_y = sat32({vel_sum[32], vel_sum});
                  if (ent_ff.init_life > ppu_pkg::TINY_LIFE) begin
                     if (ent_ff.life >= ent_ff.init_life) begin
                        ent_in.alpha = clamp_alpha({2'b00, ent_ff.init_alpha});
                        state_in = ppu_pkg::ST_WRITE;
                     end
                  end else begin
                     ent_in.alpha = clamp_alpha(short_alpha);
                     state_in = ppu_pkg::ST_WRITE;
                  end
               end
            endcase
         end

         // Restoring divide, one quotient bit a cycle
         ppu_pkg::ST_DIV: begin
            num_in = {num_ff[46:0], 1'b0};
            if (div_trial >= {1'b0, ent_ff.init_life}) begin
               rem_in = 31'(div_trial - {1'b0, ent_ff.init_life});
               quo_in = {quo_ff[15:0], 1'b1};
            end else begin
               rem_in = div_trial[30:0];
               quo_in = {quo_ff[15:0], 1'b0};
            end
            div_cnt_in = div_cnt_ff + 1'b1;
            if (div_cnt_ff == 5'(ppu_pkg::DIV_STEPS - 1)) begin
               ent_in.alpha = clamp_alpha({2'b00, quo_in});
               state_in = ppu_pkg::ST_WRITE;
            end
         end

         // Store a survivor, or close the walk
         ppu_pkg::ST_WRITE: begin
            if (idx_ff != count_ff) begin
               mem_we = 1'b1;
               keep_in = keep_ff + 1'b1;
               idx_in = idx_ff + 1'b1;
            end
            if (idx_in != count_ff) begin
               state_in = ppu_pkg::ST_READ;
            end else begin
               count_in = keep_in;
               idx_in = '0;
               if (keep_in == '0) begin
                  rsp_data_in = '0;
                  rsp_kind_in = ppu_pkg::KIND_EMPTY;
                  rsp_last_in = 1'b1;
                  rsp_valid_in = 1'b1;
                  state_in = ppu_pkg::ST_SEND;
               end else begin
                  state_in = ppu_pkg::ST_OREAD;
               end
            end
         end

         ppu_pkg::ST_OREAD: begin
            state_in = ppu_pkg::ST_OLOAD;
         end

         ppu_pkg::ST_OLOAD: begin
            rsp_data_in = pack_rsp(1'b0, rd_data_ff, 7'(count_ff));
            rsp_kind_in = ppu_pkg::KIND_PARTICLE;
            rsp_last_in = ((idx_ff + 1'b1) == count_ff);
            rsp_valid_in = 1'b1;
            state_in = ppu_pkg::ST_OSEND;
         end

         ppu_pkg::ST_OSEND: begin
            if (rsp_tready) begin
               rsp_valid_in = 1'b0;
               idx_in = idx_ff + 1'b1;
               state_in = rsp_last_ff ? ppu_pkg::ST_IDLE : ppu_pkg::ST_OREAD;
            end
         end

         default: state_in = ppu_pkg::ST_IDLE;
      endcase
   end

   // A dead particle reaches ST_WRITE with idx already advanced; it must not be stored.
   // That case is caught in ST_WRITE by tracking whether the last load was a survivor.
   logic live_ff, live_in;
   always_comb begin
      live_in = live_ff;
      if (state_ff == ppu_pkg::ST_LOAD) live_in = !(life_new[31] || life_new == 32'sd0);
      if (state_ff == ppu_pkg::ST_GRAVW) live_in = 1'b0;
   end

   logic wr_fire;
   assign wr_fire = mem_we && ((state_ff != ppu_pkg::ST_WRITE) || live_ff);

   // Particle memory
   always_ff @(posedge clock) begin
      if (wr_fire) begin
         mem_ff[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= mem_ff[idx_ff[ppu_pkg::IDX_W-1:0]];
   end

   // Payload registers
   always_ff @(posedge clock) begin
      ent_ff <= ent_in;
      dt_ff <= dt_in;
      gdt_ff <= gdt_in;
      step_ff <= step_in;
      prod_ff <= prod_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      num_ff <= num_in;
      div_cnt_ff <= div_cnt_in;
      rsp_data_ff <= rsp_data_in;
      rsp_kind_ff <= rsp_kind_in;
      rsp_last_ff <= rsp_last_in;
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ppu_pkg::ST_IDLE;
         count_ff <= '0;
         idx_ff <= '0;
         keep_ff <= '0;
         live_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         gravity_ff <= ppu_pkg::GRAVITY_RESET;
      end else begin
         state_ff <= state_in;
         count_ff <= (state_ff == ppu_pkg::ST_WRITE && !live_ff && idx_ff != count_ff)
                     ? count_ff : count_in;
         idx_ff <= idx_in;
         keep_ff <= (state_ff == ppu_pkg::ST_WRITE && !live_ff) ? keep_ff : keep_in;
         live_ff <= (state_ff == ppu_pkg::ST_WRITE) ? 1'b0 : live_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            gravity_ff <= csr_wr_data;
         end
      end
   end

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= ppu_pkg::CNT_W'(ppu_pkg::MAX_PARTICLES))
      else $error("pool count above capacity");
   a_ready_no_rsp: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> !rsp_valid_ff)
      else $error("ready while a response word is pending");
   a_keep_le_idx: assert property (@(posedge clock) disable iff (reset)
      keep_ff <= idx_ff || state_ff == ppu_pkg::ST_OREAD || state_ff == ppu_pkg::ST_OLOAD
      || state_ff == ppu_pkg::ST_OSEND || state_ff == ppu_pkg::ST_IDLE
      || state_ff == ppu_pkg::ST_SEND)
      else $error("compaction index ran ahead of read index");
`endif

endmodule

[verif/particle_pool_checker.sv]
module particle_pool_checker (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   input  logic         req_tready,
   input  logic [ppu_pkg::REQ_TDATA_W-1:0] req_tdata,
   input  logic         req_tuser,
   input  logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  logic [ppu_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   input  logic [1:0]   rsp_tuser,
   input  logic         rsp_tlast,
   input  logic         csr_wr_en,
   input  logic [19:0]  csr_wr_data,
   output int           fail_count,
   output int           pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   // expected response word: kind, tlast, tdata
   typedef struct {
      logic [1:0] kind;
      logic       last;
      logic [ppu_pkg::RSP_TDATA_W-1:0] data;
   } rsp_word_type;

   rsp_word_type expected_rsp[$];
   ppu_pkg::particle_type pool[ppu_pkg::MAX_PARTICLES];
   int unsigned pool_size;
   logic [19:0] gravity;

   initial begin
      fail_count = 0;
      pending_count = 0;
   end

   function automatic logic signed [31:0] sat_add(longint a, longint b);
      longint s;
      s = a + b;
      if (s > 64'sd2147483647) return 32'sh7fffffff;
      if (s < -64'sd2147483648) return 32'sh80000000;
      return s[31:0];
   endfunction

   // arithmetic shift floors toward minus infinity
   function automatic longint scale_step(longint v, longint dt);
      longint p;
      p = v * dt;
      return p >>> 16;
   endfunction

   function automatic logic [ppu_pkg::RSP_TDATA_W-1:0] pack_rsp(logic acc,
                                                                 ppu_pkg::particle_type p,
                                                                 logic [6:0] cnt);
      logic [ppu_pkg::RSP_TDATA_W-1:0] d;
      d = '0;
      d[0] = acc;
      d[32:1] = p.pos_x;
      d[64:33] = p.pos_y;
      d[96:65] = p.pos_z;
      d[113:97] = p.alpha;
      d[144:114] = p.size;
      d[168:145] = p.color;
      d[175:169] = cnt;
      return d;
   endfunction

   task automatic predict_word(logic op, logic [ppu_pkg::REQ_TDATA_W-1:0] d);
      ppu_pkg::particle_type p, blank;
      rsp_word_type w;
      longint dt, life, il, a;
      int unsigned keep;
      blank = '0;
      if (op == ppu_pkg::OP_EMIT) begin
         w.kind = ppu_pkg::KIND_EMIT;
         w.last = 1'b1;
         if (pool_size < ppu_pkg::MAX_PARTICLES) begin
            p.pos_x = d[31:0];
            p.pos_y = d[63:32];
            p.pos_z = d[95:64];
            p.vel_x = d[127:96];
            p.vel_y = d[159:128];
            p.vel_z = d[191:160];
            p.init_alpha = d[208:192];
            p.alpha = d[208:192];
            p.life = d[239:209];
            p.init_life = d[239:209];
            p.size = d[270:240];
            p.color = d[294:271];
            pool[pool_size] = p;
            pool_size++;
            w.data = pack_rsp(1'b1, blank, pool_size[6:0]);
         end else begin
            w.data = pack_rsp(1'b0, blank, pool_size[6:0]);
         end
         expected_rsp.insert(expected_rsp.size(), w);
         return;
      end
      dt = longint'(d[310:295]);
      keep = 0;
      for (int i = 0; i < pool_size; i++) begin
         p = pool[i];
         life = longint'(p.life) - dt;
         if (life <= 0) continue;
         p.life = life[30:0];
         p.pos_x = sat_add(p.pos_x, scale_step(longint'(p.vel_x), dt));
         p.pos_y = sat_add(p.pos_y, scale_step(longint'(p.vel_y), dt));
         p.pos_z = sat_add(p.pos_z, scale_step(longint'(p.vel_z), dt));
         p.vel_y = sat_add(p.vel_y, -scale_step(longint'(gravity), dt));
         il = longint'(p.init_life);
         if (il > longint'(ppu_pkg::TINY_LIFE)) begin
            if (life >= il) a = longint'(p.init_alpha);
            else a = (longint'(p.init_alpha) * life) / il;
         end else begin
            a = longint'(p.alpha) - dt;
         end
         if (a < 0) a = 0;
         if (a > longint'(ppu_pkg::ALPHA_ONE)) a = longint'(ppu_pkg::ALPHA_ONE);
         p.alpha = a[16:0];
         pool[keep] = p;
         keep++;
      end
      pool_size = keep;
      if (keep == 0) begin
         w.kind = ppu_pkg::KIND_EMPTY;
         w.last = 1'b1;
         w.data = pack_rsp(1'b0, blank, 7'd0);
         expected_rsp.insert(expected_rsp.size(), w);
      end
      for (int i = 0; i < keep; i++) begin
         w.kind = ppu_pkg::KIND_PARTICLE;
         w.last = (i + 1 == keep);
         w.data = pack_rsp(1'b0, pool[i], keep[6:0]);
         expected_rsp.insert(expected_rsp.size(), w);
      end
   endtask

   always @(posedge clock) begin
      rsp_word_type e;
      if (reset) begin
         pool_size = 0;
         gravity = ppu_pkg::GRAVITY_RESET;
         fail_count = 0;
         expected_rsp.delete();
      end else begin
         if (csr_wr_en) gravity = csr_wr_data;
         // compare outgoing words against oldest prediction
         if (rsp_tvalid && rsp_tready) begin
            if (expected_rsp.size() == 0) begin
               fail_count++;
               $display("%0t: unexpected word kind=%0d last=%0b data=%h", $time, rsp_tuser,
                        rsp_tlast, rsp_tdata);
            end else begin
               e = expected_rsp.pop_front();
               if (e.kind !== rsp_tuser || e.last !== rsp_tlast || e.data !== rsp_tdata) begin
                  fail_count++;
                  $display("%0t: mismatch expected kind=%0d last=%0b data=%h", $time, e.kind,
                           e.last, e.data);
                  $display("%0t:          actual   kind=%0d last=%0b data=%h", $time,
                           rsp_tuser, rsp_tlast, rsp_tdata);
               end
            end
         end
         if (req_tvalid && req_tready) predict_word(req_tuser, req_tdata);
      end
      pending_count = expected_rsp.size();
   end

endmodule

[verif/particle_pool_update_tb.sv]
module particle_pool_update_tb;
   timeunit 1ns;
   timeprecision 1ps;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [ppu_pkg::REQ_TDATA_W-1:0] req_tdata = '0;
   logic req_tuser = ppu_pkg::OP_EMIT;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [ppu_pkg::RSP_TDATA_W-1:0] rsp_tdata;
   logic [1:0] rsp_tuser;
   logic rsp_tlast;
   logic csr_wr_en = 1'b0;
   logic [19:0] csr_wr_data = '0;
   int fail_count, pending_count;

   // stall control: stimulus raises the requests, the receiver process counts
   bit quiet_tail = 0;
   bit long_hold = 0;
   bit long_hold_done = 0;
   int hold_cycles = 0;

   always #5 clock = ~clock;

   particle_pool_update DUT (.*);
   particle_pool_checker checker_i (.*);

   // random particle; unless wild, start alpha stays within 0..65536 and one in four lifetimes is tiny (0 to 8)
   function automatic logic [ppu_pkg::REQ_TDATA_W-1:0] make_emit(bit wild);
      logic [ppu_pkg::REQ_TDATA_W-1:0] d;
      d = '0;
      for (int k = 0; k < 9; k++) d[k*32 +: 32] = $urandom;
      d[311:288] = 24'($urandom);
      if (!wild) begin
         d[208:192] = 17'($urandom_range(0, 65536));
         d[239:209] = 31'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 8)
                                                      : $urandom_range(1, 65536 * 4));
      end
      d[311] = 1'b0;
      return d;
   endfunction

   function automatic logic [ppu_pkg::REQ_TDATA_W-1:0] make_tick(logic [15:0] dt);
      logic [ppu_pkg::REQ_TDATA_W-1:0] d;
      d = make_emit(1);
      d[310:295] = dt;
      d[311] = 1'b0;
      return d;
   endfunction

   // leaves tvalid high after the accept; the next call or idle_req takes it over
   task automatic send_word(logic op, logic [ppu_pkg::REQ_TDATA_W-1:0] d, bit gaps);
      if (gaps && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= op;
      req_tdata <= d;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   task automatic idle_req();
      req_tvalid <= 1'b0;
   endtask

   task automatic drain_and_write(logic [19:0] g);
      idle_req();
      while (pending_count != 0) @(negedge clock);
      repeat (40) @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= g;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // receiver: random stall bursts, one long hold on request, none at the end
   always @(negedge clock) begin
      if (long_hold && !long_hold_done) begin
         long_hold_done <= 1'b1;
         rsp_tready <= 1'b0;
         hold_cycles <= 299;
      end else if (hold_cycles > 0) begin
         rsp_tready <= 1'b0;
         hold_cycles <= hold_cycles - 1;
      end else if (!quiet_tail && $urandom_range(0, 4) == 0) begin
         rsp_tready <= 1'b0;
         hold_cycles <= $urandom_range(0, 4);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   initial begin
      logic [ppu_pkg::REQ_TDATA_W-1:0] d;
      repeat (4) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: empty tick, extremes, zero life, alpha above one
      send_word(ppu_pkg::OP_TICK, make_tick(16'hffff), 0);
      d = make_emit(1);
      d[31:0] = 32'h7fffffff; d[127:96] = 32'h7fffffff;
      d[63:32] = 32'h80000000; d[159:128] = 32'h80000000;
      d[208:192] = 17'h1ffff; d[239:209] = 31'h7fffffff;
      d[270:240] = 31'h7fffffff; d[294:271] = 24'hffffff;
      send_word(ppu_pkg::OP_EMIT, d, 0);
      d[208:192] = 17'd65536; d[239:209] = 31'd0; d[270:240] = '0; d[294:271] = '0;
      send_word(ppu_pkg::OP_EMIT, d, 0);
      d[239:209] = 31'd5; d[208:192] = 17'd70000;
      send_word(ppu_pkg::OP_EMIT, d, 0);
      send_word(ppu_pkg::OP_TICK, make_tick(16'd1), 0);
      send_word(ppu_pkg::OP_TICK, make_tick(16'd0), 0);
      send_word(ppu_pkg::OP_TICK, make_tick(16'hffff), 0);
      drain_and_write(20'hfffff);

      // fill past capacity while the receiver holds off
      long_hold = 1;
      for (int i = 0; i < 66; i++) send_word(ppu_pkg::OP_EMIT, make_emit(0), 0);
      send_word(ppu_pkg::OP_TICK, make_tick(16'd100), 0);
      drain_and_write(20'd0);

      // random phases at several gravity settings
      for (int ph = 0; ph < 4; ph++) begin
         for (int i = 0; i < 90; i++) begin
            if (ph == 3 && i == 60) quiet_tail = 1;
            if ($urandom_range(0, 2) == 0)
               send_word(ppu_pkg::OP_TICK,
                         make_tick(16'(($urandom_range(0, 3) == 0) ? $urandom
                                                                  : $urandom_range(0, 20000))),
                         ph != 3 || i < 60);
            else
               send_word(ppu_pkg::OP_EMIT, make_emit($urandom_range(0, 9) == 0),
                         ph != 3 || i < 60);
         end
         if (ph < 3) drain_and_write(ph == 0 ? ppu_pkg::GRAVITY_RESET : 20'($urandom));
      end

      idle_req();
      while (pending_count != 0) @(negedge clock);
      repeat (100) @(negedge clock);
      if (fail_count == 0)
         $display("particle_pool_update_tb passed");
      else
         $display("particle_pool_update_tb failed");
      $finish;
   end

   initial begin
      #100ms;
      $display("particle_pool_update_tb failed");
      $finish;
   end

endmodule
